/* design/hlbc_pkg.sv */
package hlbc_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_GET     = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_PIN     = 2'd2;
    localparam logic [1:0] KIND_UNPIN   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_BUF    = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    localparam logic [7:0] REFS_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  device_id;
        logic [31:0] block_number;
        logic [4:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [4:0] slot_granted;
        logic       needs_read;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HMOD,
        ST_MATCH,
        ST_FREE,
        ST_NEXTBK,
        ST_COMMIT,
        ST_RMOD,
        ST_SLOT,
        ST_OUT
    } state_t;

endpackage

/* design/hlbc_mod.sv */
// Remainder of a 32-bit value by a small constant divisor, shown while done is high.
// The value is registered at start; its four bytes are then folded with the
// constant weights 2^(8k) mod DIVISOR into a registered 14-bit sum, whose remainder
// comes by a reciprocal multiplication that is exact for every 14-bit sum.
module hlbc_mod #(
    parameter int DIVISOR = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] value,
    output logic        done,
    output logic [4:0]  rem
);
    localparam logic [3:0]  C1    = 4'((1 << 8) % DIVISOR);
    localparam logic [3:0]  C2    = 4'((1 << 16) % DIVISOR);
    localparam logic [3:0]  C3    = 4'((1 << 24) % DIVISOR);
    localparam logic [18:0] RECIP = 19'(((1 << 18) + DIVISOR - 1) / DIVISOR);
    localparam logic [13:0] DIV   = 14'(DIVISOR);

    logic [31:0] val_reg, val_next;
    logic [13:0] sum_reg, sum_next;
    logic [1:0]  phase_reg, phase_next;
    logic [13:0] fold;
    logic [32:0] prod;
    logic [13:0] quo;
    logic [13:0] diff;

    // Byte fold: every weight is below the divisor, so the sum fits 14 bits.
    assign fold = 14'(val_reg[7:0]) +
                  14'(val_reg[15:8]) * 14'(C1) +
                  14'(val_reg[23:16]) * 14'(C2) +
                  14'(val_reg[31:24]) * 14'(C3);

    // Quotient of the folded sum by reciprocal multiplication, then the remainder.
    assign prod = 33'(sum_reg) * 33'(RECIP);
    assign quo  = 14'(prod >> 18);
    assign diff = sum_reg - quo * DIV;

    // Phase sequencing: load, fold, result.
    always_comb
    begin
        val_next   = val_reg;
        sum_next   = sum_reg;
        phase_next = phase_reg;
        if (start)
        begin
            val_next   = value;
            phase_next = 2'd1;
        end
        else if (phase_reg == 2'd1)
        begin
            sum_next   = fold;
            phase_next = 2'd2;
        end
        else if (phase_reg == 2'd2)
            phase_next = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 2'd0;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        sum_reg <= sum_next;
    end

    assign done = (phase_reg == 2'd2);
    assign rem  = 5'(diff);

endmodule

/* design/hashed_lru_buffer_cache.sv */
// Tag and LRU policy engine of a hashed disk block cache.
// The req channel takes one request transaction (get, release, pin, unpin)
// and the rsp channel returns exactly one result transaction for it, in order.
// A get first reduces the block number modulo the bucket count in the fold and
// reciprocal unit, then walks every slot once for the most recent match. A miss
// walks the home bucket again for the oldest free slot, and on failure tries
// further buckets for a steal, up to NUM_BUCKETS - 1 of them in the worst case.
// A release that drops the count to zero reduces the slot's block number the
// same way and moves the slot to that bucket with a fresh stamp; every other
// release, pin or unpin goes straight to the output stage.
// One request is processed at a time; req_ready is high only in idle, and it
// rises at the same clock edge as the result enters the output register. When
// the receiver stalls, one result waits in the output register while the next
// request is processed; its result then waits and req_ready stays low until
// rsp_ready returns.
// Reset is immediate: slot i lands in bucket i mod NUM_BUCKETS with stamp i,
// and all counts, tags and filled flags are zero.
module hashed_lru_buffer_cache #(
    parameter int NUM_BUFS    = 32,
    parameter int NUM_BUCKETS = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  hlbc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output hlbc_pkg::rsp_t rsp
);
    import hlbc_pkg::*;

    localparam int SW = (NUM_BUFS > 1) ? $clog2(NUM_BUFS) : 1;
    localparam logic [SW:0]  NB_LAST = (SW + 1)'(NUM_BUFS - 1);
    localparam logic [3:0]   BK_LAST = 4'(NUM_BUCKETS - 1);

    // Slot state, one register per slot.
    logic [7:0]  dev_reg    [NUM_BUFS];
    logic [31:0] blk_reg    [NUM_BUFS];
    logic [7:0]  refs_reg   [NUM_BUFS];
    logic        filled_reg [NUM_BUFS];
    logic [3:0]  bucket_reg [NUM_BUFS];
    logic [31:0] stamp_reg  [NUM_BUFS];
    logic [31:0] counter_reg;

    state_t      state_reg, state_next;
    req_t        req_reg;
    rsp_t        rsp_reg;
    rsp_t        out_reg;
    logic        out_valid_reg;
    logic [SW-1:0] idx_reg;
    logic [3:0]  home_reg, bk_reg, bkcnt_reg;
    logic        found_reg, steal_reg, hit_reg;
    logic [SW-1:0] pick_reg;
    logic [31:0] pstamp_reg;

    logic        mod_start, mod_done;
    logic [4:0]  mod_rem;
    logic [31:0] mod_value;
    logic        scan_last;
    logic        match_hit, free_hit;
    logic [SW-1:0] sidx;
    logic        sidx_ok;

    assign sidx_ok   = ({4'b0, req_reg.slot_index} < 9'(NUM_BUFS));
    assign sidx      = SW'(req_reg.slot_index);
    assign scan_last = ({1'b0, idx_reg} == NB_LAST);
    assign match_hit = (bucket_reg[idx_reg] == home_reg) &&
                       (dev_reg[idx_reg] == req_reg.device_id) &&
                       (blk_reg[idx_reg] == req_reg.block_number) &&
                       (!found_reg || stamp_reg[idx_reg] > pstamp_reg);
    assign free_hit  = (bucket_reg[idx_reg] == bk_reg) && (refs_reg[idx_reg] == 8'd0) &&
                       (!found_reg || stamp_reg[idx_reg] < pstamp_reg);
    assign mod_value = (state_reg == ST_IDLE) ? req.block_number : blk_reg[sidx];

    hlbc_mod #(.DIVISOR(NUM_BUCKETS)) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (mod_value),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_valid)
                    state_next = (req.kind == KIND_GET) ? ST_HMOD : ST_SLOT;
            ST_HMOD:
                if (mod_done)
                    state_next = ST_MATCH;
            ST_MATCH:
                if (scan_last)
                    state_next = (found_reg || match_hit) ? ST_COMMIT : ST_FREE;
            ST_FREE:
                if (scan_last)
                    state_next = (found_reg || free_hit) ? ST_COMMIT : ST_NEXTBK;
            ST_NEXTBK:
                state_next = (bkcnt_reg == BK_LAST) ? ST_COMMIT : ST_FREE;
            ST_COMMIT:
                state_next = ST_OUT;
            ST_SLOT:
                if (sidx_ok && req_reg.kind == KIND_RELEASE && refs_reg[sidx] == 8'd1)
                    state_next = ST_RMOD;
                else
                    state_next = ST_OUT;
            ST_RMOD:
                if (mod_done)
                    state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || rsp_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        rsp_valid = out_valid_reg;
        mod_start = (state_reg == ST_IDLE && req_valid && req.kind == KIND_GET) ||
                    (state_reg == ST_SLOT && state_next == ST_RMOD);
    end
    assign rsp = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Output register: takes a finished result once the previous one has left.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (state_reg == ST_OUT && (!out_valid_reg || rsp_ready))
        begin
            out_reg       <= rsp_reg;
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    // Scan datapath and slot updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFS; i++)
            begin
                dev_reg[i]    <= '0;
                blk_reg[i]    <= '0;
                refs_reg[i]   <= '0;
                filled_reg[i] <= 1'b0;
                bucket_reg[i] <= 4'(i % NUM_BUCKETS);
                stamp_reg[i]  <= 32'(i);
            end
            counter_reg <= 32'(NUM_BUFS);
            req_reg     <= '0;
            rsp_reg     <= '0;
            idx_reg     <= '0;
            home_reg    <= '0;
            bk_reg      <= '0;
            bkcnt_reg   <= '0;
            found_reg   <= 1'b0;
            steal_reg   <= 1'b0;
            hit_reg     <= 1'b0;
            pick_reg    <= '0;
            pstamp_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (req_valid)
                    begin
                        req_reg   <= req;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        steal_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                    end
                ST_HMOD:
                    if (mod_done)
                    begin
                        home_reg  <= 4'(mod_rem);
                        bk_reg    <= 4'(mod_rem);
                        bkcnt_reg <= '0;
                    end
                ST_MATCH, ST_FREE:
                begin
                    if ((state_reg == ST_MATCH) ? match_hit : free_hit)
                    begin
                        found_reg  <= 1'b1;
                        pick_reg   <= idx_reg;
                        pstamp_reg <= stamp_reg[idx_reg];
                    end
                    if (scan_last)
                    begin
                        idx_reg <= '0;
                        if (state_reg == ST_MATCH)
                            hit_reg <= found_reg || match_hit;
                        if (state_reg == ST_MATCH && !(found_reg || match_hit))
                            found_reg <= 1'b0;
                    end
                    else
                        idx_reg <= idx_reg + SW'(1);
                end
                ST_NEXTBK:
                begin
                    steal_reg <= 1'b1;
                    bkcnt_reg <= bkcnt_reg + 4'd1;
                    bk_reg    <= (bk_reg == BK_LAST) ? 4'd0 : bk_reg + 4'd1;
                end
                ST_COMMIT:
                begin
                    if (!found_reg)
                    begin
                        rsp_reg <= '{slot_granted: 5'd0, needs_read: 1'b0,
                                     status: STATUS_NO_BUF};
                    end
                    else if (hit_reg)
                    begin
                        // Hit: bump the count and keep the stamp.
                        if (refs_reg[pick_reg] != REFS_MAX)
                            refs_reg[pick_reg] <= refs_reg[pick_reg] + 8'd1;
                        rsp_reg <= '{slot_granted: 5'(pick_reg),
                                     needs_read: !filled_reg[pick_reg],
                                     status: STATUS_OK};
                        filled_reg[pick_reg] <= 1'b1;
                    end
                    else
                    begin
                        // Recycle, and move home when taken from another bucket.
                        dev_reg[pick_reg]    <= req_reg.device_id;
                        blk_reg[pick_reg]    <= req_reg.block_number;
                        refs_reg[pick_reg]   <= 8'd1;
                        filled_reg[pick_reg] <= 1'b1;
                        rsp_reg <= '{slot_granted: 5'(pick_reg), needs_read: 1'b1,
                                     status: STATUS_OK};
                        if (steal_reg)
                        begin
                            bucket_reg[pick_reg] <= home_reg;
                            stamp_reg[pick_reg]  <= counter_reg;
                            counter_reg          <= counter_reg + 32'd1;
                        end
                    end
                end
                ST_SLOT:
                begin
                    rsp_reg <= '{slot_granted: req_reg.slot_index, needs_read: 1'b0,
                                 status: (sidx_ok && req_reg.kind != KIND_PIN &&
                                          refs_reg[sidx] == 8'd0) ?
                                         STATUS_UNDERFLOW : STATUS_OK};
                    if (sidx_ok)
                    begin
                        if (req_reg.kind == KIND_PIN)
                        begin
                            if (refs_reg[sidx] != REFS_MAX)
                                refs_reg[sidx] <= refs_reg[sidx] + 8'd1;
                        end
                        else if (refs_reg[sidx] != 8'd0)
                            refs_reg[sidx] <= refs_reg[sidx] - 8'd1;
                    end
                end
                ST_RMOD:
                    if (mod_done)
                    begin
                        bucket_reg[sidx] <= 4'(mod_rem);
                        stamp_reg[sidx]  <= counter_reg;
                        counter_reg      <= counter_reg + 32'd1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // A request is taken only in idle, so the cycle after it is never ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status != 2'd3)
        else $error("bad status");

endmodule

/* dv/hashed_lru_buffer_cache_test.sv */
module hashed_lru_buffer_cache_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hlbc_pkg::*;

    localparam int NBUF = 32;
    localparam int NBKT = 13;

    // Tag model of the cache and the queue of responses it predicts.
    class cache_scoreboard;
        logic [7:0]  dev_tag [NBUF];
        logic [31:0] blk_tag [NBUF];
        logic [7:0]  refs [NBUF];
        bit          filled [NBUF];
        logic [3:0]  bucket [NBUF];
        logic [31:0] stamp [NBUF];
        logic [31:0] next_stamp;
        rsp_t        pending_rsps [$];
        int          errors;

        function void clear();
            for (int i = 0; i < NBUF; i++)
            begin
                dev_tag[i] = '0;
                blk_tag[i] = '0;
                refs[i] = '0;
                filled[i] = 0;
                bucket[i] = 4'(i % NBKT);
                stamp[i] = 32'(i);
            end
            next_stamp = 32'(NBUF);
            errors = 0;
        endfunction

        // Least recent unreferenced slot of a bucket, or -1.
        function int oldest_idle(int bk);
            int pick;
            pick = -1;
            for (int i = 0; i < NBUF; i++)
                if (bucket[i] == bk && refs[i] == 0 && (pick < 0 || stamp[i] < stamp[pick]))
                    pick = i;
            return pick;
        endfunction

        // Note an accepted request transaction and predict its response.
        function void note_request(req_t r);
            rsp_t e;
            int   home;
            int   pick;
            int   s;
            e = '0;
            s = r.slot_index;
            if (r.kind == KIND_GET)
            begin
                home = r.block_number % NBKT;
                pick = -1;
                for (int i = 0; i < NBUF; i++)
                    if (bucket[i] == home && dev_tag[i] == r.device_id
                        && blk_tag[i] == r.block_number
                        && (pick < 0 || stamp[i] > stamp[pick]))
                        pick = i;
                if (pick >= 0)
                begin
                    if (refs[pick] != REFS_MAX) refs[pick]++;
                end
                else
                begin
                    pick = oldest_idle(home);
                    if (pick < 0)
                    begin
                        for (int k = 1; k < NBKT && pick < 0; k++)
                            pick = oldest_idle((home + k) % NBKT);
                        if (pick >= 0)
                        begin
                            bucket[pick] = 4'(home);
                            stamp[pick] = next_stamp;
                            next_stamp++;
                        end
                    end
                    if (pick >= 0)
                    begin
                        dev_tag[pick] = r.device_id;
                        blk_tag[pick] = r.block_number;
                        filled[pick] = 0;
                        refs[pick] = 8'd1;
                    end
                end
                if (pick < 0)
                    e.status = STATUS_NO_BUF;
                else
                begin
                    e.slot_granted = 5'(pick);
                    e.needs_read = !filled[pick];
                    filled[pick] = 1;
                end
            end
            else
            begin
                e.slot_granted = r.slot_index;
                if (r.kind == KIND_PIN)
                begin
                    if (refs[s] != REFS_MAX) refs[s]++;
                end
                else if (refs[s] == 0)
                    e.status = STATUS_UNDERFLOW;
                else
                begin
                    refs[s]--;
                    if (r.kind == KIND_RELEASE && refs[s] == 0)
                    begin
                        bucket[s] = 4'(blk_tag[s] % NBKT);
                        stamp[s] = next_stamp;
                        next_stamp++;
                    end
                end
            end
            pending_rsps.push_back(e);
        endfunction

        // Compare a response transaction with the oldest prediction.
        function void check_response(rsp_t a);
            rsp_t e;
            if (pending_rsps.size() == 0)
            begin
                $error("unexpected response %p", a);
                errors++;
                return;
            end
            e = pending_rsps.pop_front();
            if (a.slot_granted !== e.slot_granted)
            begin
                $error("slot_granted expected %0d actual %0d", e.slot_granted, a.slot_granted);
                errors++;
            end
            if (a.needs_read !== e.needs_read)
            begin
                $error("needs_read expected %0d actual %0d", e.needs_read, a.needs_read);
                errors++;
            end
            if (a.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, a.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   hold_cycles;
    cache_scoreboard board;

    hashed_lru_buffer_cache u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offer one request transaction and wait until it is taken. Valid stays
    // high until the caller offers the next one or drops it at this falling edge.
    task automatic send_request(input req_t r);
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!(req_valid && req_ready));
        board.note_request(r);
        @(negedge clk);
    endtask

    task automatic send_with_gap(input req_t r, input bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        send_request(r);
    endtask

    function automatic req_t make_req(logic [1:0] k, logic [7:0] d, logic [31:0] b, logic [4:0] s);
        req_t r;
        r.kind = k;
        r.device_id = d;
        r.block_number = b;
        r.slot_index = s;
        return r;
    endfunction

    // Random requests drawn from a small working set so that hits happen.
    function automatic req_t random_req(bit wide);
        req_t r;
        int   p;
        r.kind = 2'($urandom_range(0, 3));
        r.device_id = wide ? 8'($urandom) : 8'($urandom_range(0, 2));
        r.block_number = wide ? $urandom : 32'($urandom_range(0, 40));
        r.slot_index = 5'($urandom);
        p = $urandom_range(0, 9);
        if (p < 5) r.kind = KIND_GET;
        else if (p < 8) r.kind = KIND_RELEASE;
        return r;
    endfunction

    // Response side: random stalls, plus one long hold-off on request.
    initial
    begin
        int g;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                    @(negedge clk);
                end
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            board.check_response(rsp);

    initial
    begin
        #200ms;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        req_t r;
        int   n;
        board = new();
        board.clear();
        req_valid = 1'b0;
        req = '0;
        hold_cycles = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: underflow at reset, extremes, hits, pin saturation.
        send_request(make_req(KIND_RELEASE, 8'd0, 32'd0, 5'd0));
        send_request(make_req(KIND_UNPIN, 8'd0, 32'd0, 5'd31));
        send_request(make_req(KIND_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31));
        send_request(make_req(KIND_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0));
        send_request(make_req(KIND_GET, 8'd0, 32'd0, 5'd0));
        send_request(make_req(KIND_PIN, 8'd0, 32'd0, 5'd7));
        send_request(make_req(KIND_UNPIN, 8'd0, 32'd0, 5'd7));
        send_request(make_req(KIND_UNPIN, 8'd0, 32'd0, 5'd7));
        for (int i = 0; i < 257; i++)
            send_request(make_req(KIND_PIN, 8'd0, 32'd0, 5'd3));
        // Exhaust every slot through one bucket to force steals and no-buffer.
        for (int i = 0; i < 34; i++)
            send_request(make_req(KIND_GET, 8'd5, 32'(i * NBKT + 4), 5'd0));
        for (int i = 0; i < NBUF; i++)
            for (int j = 0; j < 2; j++)
                send_request(make_req(KIND_RELEASE, 8'd0, 32'd0, 5'(i)));
        for (int i = 0; i < 10; i++)
            send_request(make_req(KIND_UNPIN, 8'd0, 32'd0, 5'd3));

        // Long receiver hold-off while requests keep coming.
        hold_cycles = 400;
        for (n = 0; n < 250; n++)
        begin
            r = random_req($urandom_range(0, 7) == 0);
            send_with_gap(r, n < 20 || $urandom_range(0, 3) == 0);
            // Keep counts from piling up so misses keep finding free slots.
            if ($urandom_range(0, 30) == 0)
                for (int i = 0; i < NBUF; i++)
                    if (board.refs[i] != 0)
                        send_request(make_req(KIND_RELEASE, 8'd0, 32'd0, 5'(i)));
        end
        req_valid <= 1'b0;

        while (board.pending_rsps.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending_rsps.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
